### rtl/ufeg_pkg.sv
package ufeg_pkg;

  // Configuration register map.
  localparam int unsigned CFG_NUM_REGS = 2;
  localparam int unsigned CFG_IDX_W    = $clog2(CFG_NUM_REGS);
  localparam int unsigned CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_SHOW_MS = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] HOLD_MS_RST       = 8'd0;
  localparam logic [CFG_DATA_W-1:0] ERROR_SHOW_MS_RST = 8'd100;

  localparam int unsigned MS_W = 8;

  typedef logic [MS_W-1:0] ms_t;

  typedef struct packed {
    logic ms_tick;
    logic overrun_event;
    logic framing_event;
    logic line_high;
  } in_item_t;

  typedef struct packed {
    logic rx_enable;
    logic error_led;
    logic error_recent;
  } out_item_t;

  typedef struct packed {
    ms_t  ms_count;
    ms_t  last_error_stamp;
    logic recent_flag;
    logic framing_active;
    logic rx_disabled;
    ms_t  last_low_stamp;
  } guard_state_t;

  typedef struct packed {
    ms_t hold_ms;
    ms_t error_show_ms;
  } guard_cfg_t;

endpackage

### rtl/ufeg_in_if.sv
interface ufeg_in_if;
  logic valid;
  logic ready;
  logic ms_tick;
  logic overrun_event;
  logic framing_event;
  logic line_high;

  modport source (
    output valid, ms_tick, overrun_event, framing_event, line_high,
    input  ready
  );

  modport sink (
    input  valid, ms_tick, overrun_event, framing_event, line_high,
    output ready
  );
endinterface

### rtl/ufeg_out_if.sv
interface ufeg_out_if;
  logic valid;
  logic ready;
  logic rx_enable;
  logic error_led;
  logic error_recent;

  modport source (
    output valid, rx_enable, error_led, error_recent,
    input  ready
  );

  modport sink (
    input  valid, rx_enable, error_led, error_recent,
    output ready
  );
endinterface

### rtl/ufeg_in_stage.sv
module ufeg_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ufeg_pkg::in_item_t in_item,
  output logic               stg_valid,
  input  logic               stg_take,
  output ufeg_pkg::in_item_t stg_item
);
  import ufeg_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // The stage can refill in the same cycle that its current transaction moves on.
  assign in_ready  = !valid_r || stg_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !stg_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;
endmodule

### rtl/ufeg_step.sv
module ufeg_step (
  input  ufeg_pkg::guard_state_t st,
  input  ufeg_pkg::guard_cfg_t   cfg,
  input  ufeg_pkg::in_item_t     item,
  output ufeg_pkg::guard_state_t st_nxt,
  output ufeg_pkg::out_item_t    res
);
  import ufeg_pkg::*;

  ms_t  cnt;
  ms_t  since_err;
  ms_t  since_low;
  logic err;
  logic recent;
  logic fa;
  logic dis;
  ms_t  lls;

  always_comb begin
    cnt       = st.ms_count + MS_W'(item.ms_tick);
    since_err = cnt - st.last_error_stamp;
    recent    = st.recent_flag && !(since_err > cfg.error_show_ms);
    err       = item.overrun_event;
    fa        = st.framing_active;
    dis       = st.rx_disabled;
    lls       = st.last_low_stamp;

    if (item.framing_event) begin
      fa  = 1'b1;
      err = 1'b1;
      if (cfg.hold_ms != '0) begin
        dis = 1'b1;
        lls = cnt;
      end
    end

    if (fa) begin
      if (!item.line_high) begin
        err = 1'b1;
      end else begin
        fa = 1'b0;
      end
    end

    since_low = cnt - lls;
    if (dis) begin
      if (!item.line_high) begin
        lls = cnt;
      end else if (since_low > cfg.hold_ms) begin
        dis = 1'b0;
      end
    end

    st_nxt.ms_count         = cnt;
    st_nxt.last_error_stamp = err ? cnt : st.last_error_stamp;
    st_nxt.recent_flag      = recent || err;
    st_nxt.framing_active   = fa;
    st_nxt.rx_disabled      = dis;
    st_nxt.last_low_stamp   = lls;

    res.rx_enable    = !dis;
    res.error_led    = recent || err || dis;
    res.error_recent = recent || err;
  end
endmodule

### rtl/uart_framing_error_guard_core.sv
// Channel  | Direction | Payload                                          | Handshake
// in_ch    | sink      | ms_tick, overrun_event, framing_event, line_high | valid/ready
// out_ch   | source    | rx_enable, error_led, error_recent               | valid/ready
// cfg_*    | sink      | cfg_index selects hold_ms or error_show_ms       | cfg_we only
//
// Each transaction passes through the input register and then the result register. Its
// result is presented on out_ch once it has moved into the result register. One
// transaction per cycle is sustained while out_ch does not stall; the single guard-state
// update per cycle sets that figure.
// Reset (synchronous, rst_n low) clears the guard state and both valid bits and loads
// the register defaults. A stall on out_ch holds the result register and the input
// register fills behind it; in_ch stalls only when both are occupied.
module uart_framing_error_guard_core (
  input  logic                               clk,
  input  logic                               rst_n,
  ufeg_in_if.sink                            in_ch,
  ufeg_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [ufeg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ufeg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ufeg_pkg::*;

  // Configuration registers. User must write only while the block is idle (unchecked).
  guard_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ms       <= HOLD_MS_RST;
      cfg_r.error_show_ms <= ERROR_SHOW_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_MS:       cfg_r.hold_ms       <= cfg_data;
        CFG_ERROR_SHOW_MS: cfg_r.error_show_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage.
  in_item_t in_item;
  in_item_t stg_item;
  logic     stg_valid;
  logic     stg_take;
  logic     out_valid_r;
  logic     out_valid_nxt;

  assign in_item.ms_tick       = in_ch.ms_tick;
  assign in_item.overrun_event = in_ch.overrun_event;
  assign in_item.framing_event = in_ch.framing_event;
  assign in_item.line_high     = in_ch.line_high;

  // A staged transaction moves into the result register when that register is empty
  // or its current result is being taken in this cycle.
  assign stg_take = stg_valid && (!out_valid_r || out_ch.ready);

  ufeg_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .stg_valid (stg_valid),
    .stg_take  (stg_take),
    .stg_item  (stg_item)
  );

  // Guard state advances exactly once for each transaction, at the moment it
  // moves into the result register.
  guard_state_t st_r;
  guard_state_t st_nxt;
  out_item_t    res;
  out_item_t    out_r;

  ufeg_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (stg_item),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (stg_take) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid_nxt = stg_take || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.rx_enable    = out_r.rx_enable;
  assign out_ch.error_led    = out_r.error_led;
  assign out_ch.error_recent = out_r.error_recent;
endmodule
